// ===== design/bps_pkg.sv =====
// Shared constants and beat types for the byte permutation shuffle.
package bps_pkg;

  localparam int TableSize  = 256;
  localparam int IdxW       = $clog2(TableSize);
  localparam int ScaleShift = 9;
  localparam int SumW       = IdxW + 1;
  localparam int ProdW      = SumW + IdxW;
  localparam int QueueDepth = 2;

  localparam logic [IdxW-1:0] LastPos = IdxW'(TableSize - 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] random_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] position;
    logic       last_of_block;
  } out_beat_t;

  // Work handed from the front to the back: selection index and position.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] pos;
  } job_t;

endpackage

// ===== design/byte_permutation_shuffle_top.sv =====
// Top level of the byte permutation shuffle.
//
// Builds a permutation of 0..255 per 256-byte block, Fisher-Yates style.
// Each input beat carries a data byte and a random byte for the current
// position (255 down to 0); the block returns one beat per input beat with
// the selected table entry, its position, and a last_of_block flag at
// position 0. Sustained rate is one beat per clock while the output is not
// stalled; a beat passes the job queue, the registered table read and the
// output register. The front end computes the index
// ((random + data) * position) >> 9 with one 9x8 multiply straight into a
// 2-entry job queue; the back end reads the 256x8 table at index and
// position through a two-read-port RAM, then writes the entry at position
// back to index. A one-deep forwarding register covers the write landing
// on the same edge as the next read, which is what lets a new beat enter
// every cycle. Written marks live in flops and clear at once on the last
// beat of a block, so there is no clearing pass after reset. Input
// back-pressure appears only when the queue fills behind a stalled output.
module byte_permutation_shuffle_top import bps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic push, push_ready, head_valid, pop;
  job_t job, head;

  // Front: position count and index.
  bps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat_i),
    .push_o       (push),
    .job_o        (job),
    .push_ready_i (push_ready)
  );

  // Decouples the front from back-end stalls.
  bps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Back: table update and result beat.
  bps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_beat_o   (out_beat_o)
  );

endmodule

// ===== design/bps_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
module bps_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/bps_front.sv =====
// Front end: position counter and selection index for each accepted beat.
module bps_front import bps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_beat_i,
  output logic     push_o,
  output job_t     job_o,
  input  logic     push_ready_i
);

  logic [IdxW-1:0]  pos_q, pos_d;
  logic [SumW-1:0]  sum;
  logic [ProdW-1:0] prod;
  logic             accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;

  // floor((r + d) * pos / 512), never above pos
  assign sum  = {1'b0, in_beat_i.data_byte} + {1'b0, in_beat_i.random_byte};
  assign prod = ProdW'(sum) * ProdW'(pos_q);

  assign push_o    = accept;
  assign job_o.idx = prod[ScaleShift +: IdxW];
  assign job_o.pos = pos_q;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = (pos_q == '0) ? LastPos : pos_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= LastPos;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== design/bps_queue.sv =====
// Short job queue between front and back.
module bps_queue import bps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic push_ready_o,
  output logic head_valid_o,
  output job_t head_o,
  input  logic pop_i
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/bps_back.sv =====
// Back end: table read-modify-write with forwarding, written marks, output register.
module bps_back import bps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic            d_valid_q;
  job_t            d_job_q;
  logic            d_fire;
  logic            byp_valid_q;
  logic [IdxW-1:0] byp_addr_q;
  logic [7:0]      byp_data_q;
  logic [7:0]      rdata_sel, rdata_repl;
  logic [7:0]      sel_raw, repl_raw, sel, repl;
  logic [TableSize-1:0] mark_q;
  logic            out_valid_q;
  out_beat_t       out_beat_q;

  assign d_fire = d_valid_q & (~out_valid_q | out_ready_i);
  assign pop_o  = head_valid_i & (~d_valid_q | d_fire);

  bps_ram #(
    .Width (8),
    .Depth (TableSize)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (d_fire),
    .waddr_i   (d_job_q.idx),
    .wdata_i   (repl),
    .re_i      (pop_o),
    .raddr_a_i (head_i.idx),
    .raddr_b_i (head_i.pos),
    .rdata_a_o (rdata_sel),
    .rdata_b_o (rdata_repl)
  );

  // The read missed the write committed on the same edge; forward it.
  assign sel_raw  = (byp_valid_q && byp_addr_q == d_job_q.idx) ? byp_data_q : rdata_sel;
  assign repl_raw = (byp_valid_q && byp_addr_q == d_job_q.pos) ? byp_data_q : rdata_repl;
  // Unwritten entries read as their own index.
  assign sel  = mark_q[d_job_q.idx] ? sel_raw  : d_job_q.idx;
  assign repl = mark_q[d_job_q.pos] ? repl_raw : d_job_q.pos;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      d_job_q    <= head_i;
      byp_addr_q <= d_job_q.idx;
      byp_data_q <= repl;
    end
    if (d_fire) begin
      out_beat_q.out_byte      <= sel;
      out_beat_q.position      <= d_job_q.pos;
      out_beat_q.last_of_block <= (d_job_q.pos == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q   <= 1'b0;
      byp_valid_q <= 1'b0;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        d_valid_q   <= 1'b1;
        byp_valid_q <= d_fire;
      end else if (d_fire) begin
        d_valid_q   <= 1'b0;
      end
      if (d_fire) begin
        if (d_job_q.pos == '0) begin
          mark_q <= '0;
        end else begin
          mark_q[d_job_q.idx] <= 1'b1;
        end
      end
      if (d_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

`ifndef SYNTH
  a_idx_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid_q |-> (d_job_q.idx <= d_job_q.pos))
    else $error("selection index above position");

  a_marks_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_fire && d_job_q.pos == '0) |=> (mark_q == '0))
    else $error("written marks not cleared at block end");

  a_mark_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_fire && d_job_q.pos != '0) |=> mark_q[$past(d_job_q.idx)])
    else $error("written mark not set after table write");

  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_fire |=> out_valid_q)
    else $error("result lost on its way to the output register");
`endif

endmodule
